>>> sv/vecnrm_pkg.sv
// ----------------------------------------------------------------------------
// vecnrm_pkg
// shared constants and types of the streaming euclidean norm block
// ----------------------------------------------------------------------------
package vecnrm_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int MAX_LEN_LOG2_DEF = 16;
   localparam int NORM_WIDTH       = 24;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                   full;
      logic                   empty;
      logic [QUEUE_CNT_W-1:0] count;
   } queue_status_type;

endpackage

>>> sv/vecnrm_if.sv
// ----------------------------------------------------------------------------
// vecnrm request and response channels
// valid/ready handshake interfaces carrying samples in and norms out
// ----------------------------------------------------------------------------
interface vecnrm_req_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample;
   logic                    last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

interface vecnrm_rsp_if #(
   parameter int NORM_WIDTH = 24
);
   logic                  valid;
   logic                  ready;
   logic [NORM_WIDTH-1:0] norm;
   logic                  saturated;

   modport source (output valid, output norm, output saturated, input ready);
   modport sink   (input valid, input norm, input saturated, output ready);
endinterface

>>> sv/vecnrm_front.sv
// ----------------------------------------------------------------------------
// vecnrm_front
// squares each sample and keeps the saturating sum of squares per vector
// ----------------------------------------------------------------------------
module vecnrm_front
   import vecnrm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int MAX_LEN_LOG2 = MAX_LEN_LOG2_DEF,
   parameter int SUM_BITS     = 2 * SAMPLE_WIDTH - 1 + MAX_LEN_LOG2
) (
   input  logic                  clock,
   input  logic                  reset,
   vecnrm_req_if.sink            req,
   input  queue_status_type      q_status,
   output logic                  push,
   output logic [SUM_BITS:0]     push_data
);

   localparam int SQ_W = 2 * SAMPLE_WIDTH;
   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

   logic [SAMPLE_WIDTH-1:0] mag;
   logic [SQ_W-1:0]         sq_in;
   logic [SQ_W-1:0]         sq_ff;
   logic                    last_ff;
   logic                    valid_ff, valid_in;
   logic [SUM_BITS-1:0]     sum_ff, sum_in;
   logic                    ovf_ff, ovf_in;
   logic [SUM_BITS:0]       sum_wide;
   logic                    sat;
   logic [SUM_BITS-1:0]     sum_sat;
   logic                    ovf_now;
   logic                    go;
   logic                    accept;

   // magnitude of the two's complement sample, most negative value included
   assign mag   = req.sample[SAMPLE_WIDTH-1] ? (~req.sample + 1'b1) : req.sample;
   assign sq_in = SQ_W'(mag) * SQ_W'(mag);

   assign go        = valid_ff && (!last_ff || !q_status.full);
   assign req.ready = !valid_ff || go;
   assign accept    = req.valid && req.ready;

   assign sum_wide = {1'b0, sum_ff} + (SUM_BITS + 1)'(sq_ff);
   assign sat      = sum_wide >= {1'b0, SUM_MAX};
   assign sum_sat  = sat ? SUM_MAX : sum_wide[SUM_BITS-1:0];
   assign ovf_now  = ovf_ff || sat;

   assign push      = go && last_ff;
   assign push_data = {ovf_now, sum_sat};

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (go) begin
         valid_in = 1'b0;
      end
      sum_in = sum_ff;
      ovf_in = ovf_ff;
      if (go) begin
         if (last_ff) begin
            sum_in = '0;
            ovf_in = 1'b0;
         end else begin
            sum_in = sum_sat;
            ovf_in = ovf_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sum_ff   <= sum_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sq_ff   <= sq_in;
         last_ff <= req.last;
      end
   end

endmodule

>>> sv/vecnrm_queue.sv
// ----------------------------------------------------------------------------
// vecnrm_queue
// short fifo of finished sums between the accumulator and the root unit
// ----------------------------------------------------------------------------
module vecnrm_queue
   import vecnrm_pkg::*;
#(
   parameter int DATA_W = 2 * SAMPLE_WIDTH_DEF + MAX_LEN_LOG2_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output queue_status_type  status
);

   logic [DATA_W-1:0]      data_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign status.count = count_ff;
   assign status.full  = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign pop_data     = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/vecnrm_back.sv
// ----------------------------------------------------------------------------
// vecnrm_back
// digit-by-digit integer square root, two sum bits per cycle, with output register
// ----------------------------------------------------------------------------
module vecnrm_back
   import vecnrm_pkg::*;
#(
   parameter int SUM_BITS = 2 * SAMPLE_WIDTH_DEF - 1 + MAX_LEN_LOG2_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_status_type      q_status,
   input  logic [SUM_BITS:0]     pop_data,
   output logic                  pop,
   vecnrm_rsp_if.source          rsp
);

   localparam int ITER  = (SUM_BITS + 1) / 2;
   localparam int PAD   = 2 * ITER;
   localparam int REM_W = ITER + 2;
   localparam int CNT_W = $clog2(ITER);
   localparam int EXT_W = (ITER > NORM_WIDTH) ? ITER : NORM_WIDTH;
   localparam logic [NORM_WIDTH-1:0] NORM_MAX = {NORM_WIDTH{1'b1}};

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [PAD-1:0]        val_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [ITER-1:0]       root_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  flag_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [NORM_WIDTH-1:0] norm_ff;
   logic                  sat_ff;

   logic [REM_W-1:0]      rem_sh;
   logic [REM_W-1:0]      trial;
   logic                  ge;
   logic [EXT_W-1:0]      root_ext;
   logic [NORM_WIDTH-1:0] norm_clamped;
   logic                  load_out;

   assign rem_sh       = {rem_ff[ITER-1:0], val_ff[PAD-1 -: 2]};
   assign trial        = {root_ff, 2'b01};
   assign ge           = rem_sh >= trial;
   assign root_ext     = EXT_W'(root_ff);
   assign norm_clamped = (root_ext > EXT_W'(NORM_MAX)) ? NORM_MAX : root_ext[NORM_WIDTH-1:0];

   assign pop      = (state_ff == ST_IDLE) && !q_status.empty;
   assign load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         val_ff  <= PAD'(pop_data[SUM_BITS-1:0]);
         flag_ff <= pop_data[SUM_BITS];
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= CNT_W'(ITER - 1);
      end else if (state_ff == ST_RUN) begin
         val_ff  <= {val_ff[PAD-3:0], 2'b00};
         rem_ff  <= ge ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[ITER-2:0], ge};
         cnt_ff  <= cnt_ff - 1'b1;
      end
      if (load_out) begin
         norm_ff <= norm_clamped;
         sat_ff  <= flag_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.norm      = norm_ff;
   assign rsp.saturated = sat_ff;

endmodule

>>> sv/vector_euclidean_norm.sv
// ----------------------------------------------------------------------------
// vector_euclidean_norm
// streaming euclidean norm of a signed fixed-point vector
// ----------------------------------------------------------------------------
// req carries one sample per request, with last set on the final element of a
// vector; rsp returns one norm per vector (floor of the root of the sum of
// squares, clamped to 24 bits) and a flag set when the sum saturated.
// the front squares and accumulates, and takes one request per cycle for as
// long as the two-entry sum queue has room when a last element arrives.
// the back runs a digit-by-digit square root, one result bit per cycle, and
// pops the next sum only once its result is in the output register; the
// queue lets the front go on taking samples while the back is busy.
// after the last request is accepted, its square is registered in the front,
// the finished sum goes through the queue, the back pops it in idle, runs the
// root and loads the result into the output register that drives rsp.
// reset clears the sum, the queue and the output valid, not the output data.
// a stalled rsp holds its result; the back then waits, the queue fills and
// req.ready drops only when a last element finds the queue full.
// ----------------------------------------------------------------------------
module vector_euclidean_norm
   import vecnrm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int MAX_LEN_LOG2 = MAX_LEN_LOG2_DEF
) (
   input  logic          clock,
   input  logic          reset,
   vecnrm_req_if.sink    req,
   vecnrm_rsp_if.source  rsp
);

   localparam int SUM_BITS = 2 * SAMPLE_WIDTH - 1 + MAX_LEN_LOG2;

   logic              push;
   logic              pop;
   logic [SUM_BITS:0] push_data;
   logic [SUM_BITS:0] pop_data;
   queue_status_type  q_status;

   vecnrm_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .MAX_LEN_LOG2 (MAX_LEN_LOG2),
      .SUM_BITS     (SUM_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   vecnrm_queue #(
      .DATA_W (SUM_BITS + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   vecnrm_back #(
      .SUM_BITS (SUM_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp      (rsp)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full && !pop))
      else $error("sum pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty))
      else $error("sum popped from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("response valid after reset");

endmodule

>>> tb/tb_vector_euclidean_norm.sv
// ----------------------------------------------------------------------------
// tb_vector_euclidean_norm
// self-checking bench for the streaming euclidean norm block
// ----------------------------------------------------------------------------
// samples stream in on the request channel and each vector is closed by its
// last flag. a model of the sum of squares, its saturation and the integer
// square root predicts one norm per vector. the monitor compares every
// returned norm in order with that prediction. a short directed part covers
// the sample extremes, single-element vectors and a few short mixed vectors.
// random vectors then run under three handshake pressure phases.
// ----------------------------------------------------------------------------
module tb_vector_euclidean_norm;
   import vecnrm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW          = SAMPLE_WIDTH_DEF;
   localparam int SUM_W       = 2 * SAMPLE_WIDTH_DEF - 1 + MAX_LEN_LOG2_DEF;
   localparam logic [47:0] SUM_CEIL = (48'h1 << SUM_W) - 48'h1;
   localparam logic [47:0] NORM_CEIL = (48'h1 << NORM_WIDTH) - 48'h1;
   localparam int RANDOM_ITEMS = 500;
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [SW-1:0] sample;
      logic          last;
      int            phase;
      bit            hold;
   } sample_req_type;

   typedef struct {
      logic [NORM_WIDTH-1:0] norm;
      logic                  saturated;
   } norm_rsp_type;

   logic clock;
   logic reset;

   vecnrm_req_if #(.SAMPLE_WIDTH(SW))         req_ch ();
   vecnrm_rsp_if #(.NORM_WIDTH(NORM_WIDTH))   rsp_ch ();

   vector_euclidean_norm dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   sample_req_type pending_samples [$];
   norm_rsp_type   expected_norms [$];

   logic [SUM_W-1:0] energy_acc;
   bit               energy_clamped;

   int  send_idle_pct [4] = '{33, 33, 54, 0};
   int  recv_idle_pct [4] = '{54, 54, 33, 0};
   int  active_phase;
   bit  req_taken;
   int  cycle_count;
   int  error_count;
   int  samples_sent;
   int  norms_seen;
   int  saturated_seen;
   int  random_items;
   int  vec_len;
   int  cur_phase;
   int  prev_phase;

   sample_req_type next_req;
   norm_rsp_type   want;

   always #5 clock = ~clock;

   function automatic logic [NORM_WIDTH-1:0] root_of(input logic [47:0] value);
      logic [47:0] rem;
      logic [47:0] acc;
      logic [47:0] probe;
      rem   = value;
      acc   = '0;
      probe = 48'h1 << 46;
      for (int i = 0; i < 24; i++) begin
         if (rem >= acc + probe) begin
            rem = rem - (acc + probe);
            acc = (acc >> 1) + probe;
         end else begin
            acc = acc >> 1;
         end
         probe = probe >> 2;
      end
      if (acc > NORM_CEIL)
         acc = NORM_CEIL;
      return acc[NORM_WIDTH-1:0];
   endfunction

   function automatic logic [SW-1:0] rand_sample();
      case ($urandom_range(9))
         0: return {1'b1, {(SW-1){1'b0}}};
         1: return {1'b0, {(SW-1){1'b1}}};
         2: return '0;
         3: return SW'($signed($urandom_range(8)) - 4);
         default: return SW'($urandom);
      endcase
   endfunction

   task automatic queue_sample(input logic [SW-1:0] s, input logic l, input int ph,
                               input bit h);
      sample_req_type item;
      item.sample = s;
      item.last   = l;
      item.phase  = ph;
      item.hold   = h;
      pending_samples.insert(pending_samples.size(), item);
   endtask

   task automatic accumulate_square(input logic [SW-1:0] s, input logic l);
      logic [47:0]  mag;
      logic [47:0]  total;
      norm_rsp_type res;
      mag   = s[SW-1] ? ((48'h1 << SW) - {32'h0, s}) : {32'h0, s};
      total = {1'b0, energy_acc} + mag * mag;
      if (total >= SUM_CEIL) begin
         total          = SUM_CEIL;
         energy_clamped = 1'b1;
      end
      energy_acc = total[SUM_W-1:0];
      if (l) begin
         res.norm      = root_of({1'b0, energy_acc});
         res.saturated = energy_clamped;
         expected_norms.insert(expected_norms.size(), res);
         energy_acc     = '0;
         energy_clamped = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input longint got,
                                  input longint exp_val);
      error_count++;
      $display("error at cycle %0d: %s, got %0d, expected %0d",
               cycle_count, what, got, exp_val);
   endtask

   // monitor and prediction at the rising edge
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            samples_sent++;
            accumulate_square(req_ch.sample, req_ch.last);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            norms_seen++;
            if (rsp_ch.saturated)
               saturated_seen++;
            if (expected_norms.size() == 0) begin
               report_mismatch("unexpected norm", rsp_ch.norm, -1);
            end else begin
               want = expected_norms.pop_front();
               if (rsp_ch.norm !== want.norm)
                  report_mismatch("norm", rsp_ch.norm, want.norm);
               if (rsp_ch.saturated !== want.saturated)
                  report_mismatch("saturated", rsp_ch.saturated, want.saturated);
            end
         end
      end
   end

   // driver and response backpressure at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct[active_phase]);
         if (!req_ch.valid || req_taken) begin
            if (pending_samples.size() != 0
                && !(pending_samples[0].hold && expected_norms.size() != 0)
                && $urandom_range(99) >= send_idle_pct[pending_samples[0].phase]) begin
               next_req = pending_samples.pop_front();
               active_phase = next_req.phase;
               req_ch.valid  <= 1'b1;
               req_ch.sample <= next_req.sample;
               req_ch.last   <= next_req.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.sample  = '0;
      req_ch.last    = 1'b0;
      rsp_ch.ready   = 1'b0;
      energy_acc     = '0;
      energy_clamped = 1'b0;
      active_phase   = 0;
      cycle_count    = 0;
      error_count    = 0;
      samples_sent   = 0;
      norms_seen     = 0;
      saturated_seen = 0;
      random_items   = 0;

      // single-element vectors at the extremes
      queue_sample(16'sd0, 1'b1, 0, 1'b0);
      queue_sample(16'h8000, 1'b1, 0, 1'b0);
      queue_sample(16'h7fff, 1'b1, 0, 1'b0);
      queue_sample(16'hffff, 1'b1, 0, 1'b0);
      queue_sample(16'h0001, 1'b1, 0, 1'b0);
      // short vectors
      queue_sample(16'd3, 1'b0, 0, 1'b0);
      queue_sample(16'hfffc, 1'b1, 0, 1'b0);
      for (int i = 0; i < 4; i++)
         queue_sample(16'h8000, i == 3, 0, 1'b0);
      queue_sample(16'h5555, 1'b0, 0, 1'b0);
      queue_sample(16'haaaa, 1'b0, 0, 1'b0);
      queue_sample(16'h7fff, 1'b0, 0, 1'b0);
      queue_sample(16'h0000, 1'b1, 0, 1'b0);

      prev_phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         cur_phase = 1 + (random_items * 3) / RANDOM_ITEMS;
         case ($urandom_range(19))
            0:        vec_len = $urandom_range(400, 100);
            1, 2, 3:  vec_len = $urandom_range(40, 9);
            default:  vec_len = $urandom_range(8, 1);
         endcase
         if (vec_len > RANDOM_ITEMS - random_items)
            vec_len = RANDOM_ITEMS - random_items;
         for (int k = 0; k < vec_len; k++)
            queue_sample(rand_sample(), k == vec_len - 1, cur_phase,
                         k == 0 && cur_phase != prev_phase);
         random_items += vec_len;
         prev_phase = cur_phase;
      end

      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (!(pending_samples.size() == 0 && !req_ch.valid && expected_norms.size() == 0)
             && cycle_count < CYCLE_LIMIT)
         @(posedge clock);

      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d norms outstanding",
                  cycle_count, expected_norms.size());
         $display("tb_vector_euclidean_norm failed");
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (expected_norms.size() != 0)
            report_mismatch("norms never returned", 0, expected_norms.size());
         $display("streamed %0d samples and checked %0d norms, %0d of them saturated",
                  samples_sent, norms_seen, saturated_seen);
         $display("sender/receiver idle mixes: 33/54, then 54/33, then none");
         if (error_count == 0) begin
            $display("tb_vector_euclidean_norm passed");
         end else begin
            $display("tb_vector_euclidean_norm failed");
         end
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/vecnrm_pkg.sv
sv/vecnrm_if.sv
sv/vecnrm_front.sv
sv/vecnrm_queue.sv
sv/vecnrm_back.sv
sv/vector_euclidean_norm.sv
tb/tb_vector_euclidean_norm.sv
